FILE: src/mrcl_pkg.sv
// package: shared constants, command codes and control structs for the memo result cache
`default_nettype none

package mrcl_pkg;

    localparam int KEY_W     = 64;
    localparam int COUNT_W   = 4;
    localparam int SLOT_W    = 3;
    localparam int DATA_W    = 64;
    localparam int CMD_W     = 2;
    localparam int RUN_MAX   = 8;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 72;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    typedef struct packed {
        logic key_eq;
        logic cnt_eq;
        logic stamp_lt;
    } cmp_res_t;

    typedef struct packed {
        logic key_we;
        logic stamp_we;
    } entry_we_t;

endpackage

`default_nettype wire

FILE: src/mrcl_cmp_unit.sv
// shared compare unit: key and count equality, stamp age order
`default_nettype none

module mrcl_cmp_unit
    import mrcl_pkg::*;
#(
    parameter int STAMP_BITS = 32
) (
    input  logic [KEY_W-1:0]      key_a,
    input  logic [KEY_W-1:0]      key_b,
    input  logic [COUNT_W-1:0]    cnt_a,
    input  logic [COUNT_W-1:0]    cnt_b,
    input  logic [STAMP_BITS-1:0] stamp_a,
    input  logic [STAMP_BITS-1:0] stamp_b,
    output cmp_res_t              res
);

    always_comb begin
        res.key_eq   = (key_a == key_b);
        res.cnt_eq   = (cnt_a == cnt_b);
        res.stamp_lt = (stamp_a < stamp_b);
    end

endmodule

`default_nettype wire

FILE: src/mrcl_entry_ram.sv
// entry tag memory: keys, counts and frame stamps, one write and one registered read port
`default_nettype none

module mrcl_entry_ram
    import mrcl_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int STAMP_BITS = 32,
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                  aclk,
    input  entry_we_t             we,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [KEY_W-1:0]      wr_key,
    input  logic [COUNT_W-1:0]    wr_count,
    input  logic [STAMP_BITS-1:0] wr_stamp,
    input  logic [IDX_W-1:0]      rd_addr,
    output logic [KEY_W-1:0]      rd_key,
    output logic [COUNT_W-1:0]    rd_count,
    output logic [STAMP_BITS-1:0] rd_stamp
);

    logic [KEY_W-1:0]      key_mem   [CAPACITY];
    logic [COUNT_W-1:0]    count_mem [CAPACITY];
    logic [STAMP_BITS-1:0] stamp_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (we.key_we) begin
            key_mem[wr_addr]   <= wr_key;
            count_mem[wr_addr] <= wr_count;
        end
        if (we.stamp_we) begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
        rd_key   <= key_mem[rd_addr];
        rd_count <= count_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/mrcl_value_ram.sv
// value slot memory: one write and one registered read port
`default_nettype none

module mrcl_value_ram #(
    parameter int DEPTH      = 512,
    parameter int VALUE_BITS = 64,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [VALUE_BITS-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [VALUE_BITS-1:0] rd_data
);

    logic [VALUE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: src/memo_result_cache_lru_core.sv
// top level: fully associative memo result cache with frame-stamp replacement
//
// input channel s_axis: one command item per handshake, cmd in tuser; the channel
// is ready only while the sequencer is idle, one item is worked on at a time.
// result channel m_axis: lookups only; hit in tuser, tlast on the final item of a run.
// lookup: the tag memory is scanned one entry per cycle through the shared compare
// unit over the U used entries, then each returned value is read from the value
// memory before it is loaded for output; a miss or zero-count hit gives one item.
// store to slot 0: a key scan of the used entries, plus a stamp scan of all CAPACITY
// entries when the key is absent and the table is full, plus a write; store to other
// slots, advance frame and clear are done in the idle state and give no item.
// results leave through an output register: when the receiver stalls the item
// holds there and the sequencer waits before loading the next one; a new command
// is taken while the final item of a lookup still waits.
// reset clears the used count, frame counter, selected entry and the sequencer;
// the memories are not cleared and no sweep is needed.
`default_nettype none

module memo_result_cache_lru_core
    import mrcl_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int OUT_SLOTS  = 8,
    parameter int VALUE_BITS = 64,
    parameter int STAMP_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // key[63:0], value_count[67:64], slot_index[70:68], store_value[134:71], pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // result_value[63:0], result_slot[66:64], pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // hit
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int DEPTH   = CAPACITY * OUT_SLOTS;
    localparam int VA_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RUN_CAP = (OUT_SLOTS < RUN_MAX) ? OUT_SLOTS : RUN_MAX;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LK_SCAN,
        ST_LK_RD,
        ST_LK_OUT,
        ST_LK_ONE,
        ST_SV_KEY,
        ST_SV_AGE,
        ST_SV_WRITE
    } state_t;

    logic [KEY_W-1:0]      in_key;
    logic [COUNT_W-1:0]    in_count;
    logic [SLOT_W-1:0]     in_slot;
    logic [VALUE_BITS-1:0] in_value;

    assign in_key   = s_axis_tdata[63:0];
    assign in_count = s_axis_tdata[67:64];
    assign in_slot  = s_axis_tdata[70:68];
    assign in_value = VALUE_BITS'(s_axis_tdata[134:71]);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [STAMP_BITS-1:0] frame_reg, frame_next;
    logic [IDX_W-1:0]      selected_reg, selected_next;
    logic [CNT_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [STAMP_BITS-1:0] oldest_reg, oldest_next;
    logic [IDX_W-1:0]      entry_reg, entry_next;
    logic [COUNT_W-1:0]    run_len_reg, run_len_next;
    logic [SLOT_W-1:0]     run_slot_reg, run_slot_next;
    logic                  hit_one_reg, hit_one_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg, out_hit_next;
    logic [DATA_W-1:0]     out_val_reg, out_val_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_last_reg, out_last_next;

    entry_we_t             ent_we;
    logic [IDX_W-1:0]      ent_waddr;
    logic [KEY_W-1:0]      q_key;
    logic [COUNT_W-1:0]    q_count;
    logic [STAMP_BITS-1:0] q_stamp;
    logic                  val_we;
    logic [VA_W-1:0]       val_waddr;
    logic [VALUE_BITS-1:0] val_wdata;
    logic [VA_W-1:0]       val_raddr;
    logic [VALUE_BITS-1:0] q_val;
    cmp_res_t              cmp;

    logic                  out_free;
    logic [CNT_W-1:0]      scan_lim;
    logic                  scan_more;
    logic [COUNT_W-1:0]    q_run;
    logic                  run_last;

    mrcl_entry_ram #(
        .CAPACITY   (CAPACITY),
        .STAMP_BITS (STAMP_BITS)
    ) u_entry_ram (
        .aclk     (aclk),
        .we       (ent_we),
        .wr_addr  (ent_waddr),
        .wr_key   (key_reg),
        .wr_count (count_reg),
        .wr_stamp (frame_reg),
        .rd_addr  (scan_cnt_reg[IDX_W-1:0]),
        .rd_key   (q_key),
        .rd_count (q_count),
        .rd_stamp (q_stamp)
    );

    mrcl_value_ram #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (val_wdata),
        .rd_addr (val_raddr),
        .rd_data (q_val)
    );

    mrcl_cmp_unit #(
        .STAMP_BITS (STAMP_BITS)
    ) u_cmp (
        .key_a   (q_key),
        .key_b   (key_reg),
        .cnt_a   (q_count),
        .cnt_b   (count_reg),
        .stamp_a (q_stamp),
        .stamp_b (oldest_reg),
        .res     (cmp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - DATA_W - SLOT_W){1'b0}}, out_slot_reg, out_val_reg};

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign scan_lim  = (state_reg == ST_SV_AGE) ? CNT_W'(CAPACITY) : used_reg;
    assign scan_more = (scan_cnt_reg < scan_lim);
    assign q_run     = (32'(q_count) > RUN_CAP) ? COUNT_W'(RUN_CAP) : q_count;
    assign run_last  = ((COUNT_W'(run_slot_reg) + COUNT_W'(1)) == run_len_reg);
    assign val_raddr = VA_W'(32'(entry_reg) * OUT_SLOTS + 32'(run_slot_reg));

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        frame_next      = frame_reg;
        selected_next   = selected_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pick_next       = pick_reg;
        oldest_next     = oldest_reg;
        entry_next      = entry_reg;
        run_len_next    = run_len_reg;
        run_slot_next   = run_slot_reg;
        hit_one_next    = hit_one_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        val_next        = val_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_hit_next    = out_hit_reg;
        out_val_next    = out_val_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        ent_we          = '0;
        ent_waddr       = pend_idx_reg;
        val_we          = 1'b0;
        val_waddr       = VA_W'(32'(pick_reg) * OUT_SLOTS);
        val_wdata       = val_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    key_next        = in_key;
                    count_next      = in_count;
                    val_next        = in_value;
                    scan_cnt_next   = '0;
                    pend_valid_next = 1'b0;
                    unique case (s_axis_tuser)
                        CMD_LOOKUP: begin
                            state_next = ST_LK_SCAN;
                        end
                        CMD_STORE: begin
                            if (in_slot == '0) begin
                                state_next = ST_SV_KEY;
                            end else if (32'(in_slot) < OUT_SLOTS) begin
                                val_we    = 1'b1;
                                val_waddr = VA_W'(32'(selected_reg) * OUT_SLOTS
                                                  + 32'(in_slot));
                                val_wdata = in_value;
                            end
                        end
                        CMD_FRAME: begin
                            if (frame_reg != STAMP_MAX) begin
                                frame_next = frame_reg + STAMP_BITS'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            used_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LK_SCAN: begin
                if (pend_valid_reg && cmp.key_eq && cmp.cnt_eq) begin
                    ent_we.stamp_we = 1'b1;
                    ent_waddr       = pend_idx_reg;
                    entry_next      = pend_idx_reg;
                    run_len_next    = q_run;
                    run_slot_next   = '0;
                    if (q_run == '0) begin
                        hit_one_next = 1'b1;
                        state_next   = ST_LK_ONE;
                    end else begin
                        state_next = ST_LK_RD;
                    end
                end else if (!pend_valid_reg && !scan_more) begin
                    hit_one_next = 1'b0;
                    state_next   = ST_LK_ONE;
                end else begin
                    pend_valid_next = scan_more;
                    pend_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    if (scan_more) begin
                        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_LK_RD: begin
                state_next = ST_LK_OUT;
            end
            ST_LK_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = 1'b1;
                    out_val_next   = DATA_W'(q_val);
                    out_slot_next  = run_slot_reg;
                    out_last_next  = run_last;
                    if (run_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        run_slot_next = run_slot_reg + SLOT_W'(1);
                        state_next    = ST_LK_RD;
                    end
                end
            end
            ST_LK_ONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_one_reg;
                    out_val_next   = '0;
                    out_slot_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_SV_KEY: begin
                if (pend_valid_reg && cmp.key_eq) begin
                    pick_next  = pend_idx_reg;
                    state_next = ST_SV_WRITE;
                end else if (!pend_valid_reg && !scan_more) begin
                    if (used_reg < CNT_W'(CAPACITY)) begin
                        pick_next  = used_reg[IDX_W-1:0];
                        used_next  = used_reg + CNT_W'(1);
                        state_next = ST_SV_WRITE;
                    end else begin
                        scan_cnt_next = '0;
                        oldest_next   = frame_reg;
                        pick_next     = '0;
                        state_next    = ST_SV_AGE;
                    end
                end else begin
                    pend_valid_next = scan_more;
                    pend_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    if (scan_more) begin
                        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_SV_AGE: begin
                if (pend_valid_reg && cmp.stamp_lt) begin
                    oldest_next = q_stamp;
                    pick_next   = pend_idx_reg;
                end
                if (!pend_valid_reg && !scan_more) begin
                    state_next = ST_SV_WRITE;
                end else begin
                    pend_valid_next = scan_more;
                    pend_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    if (scan_more) begin
                        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_SV_WRITE: begin
                ent_we.key_we   = 1'b1;
                ent_we.stamp_we = 1'b1;
                ent_waddr       = pick_reg;
                val_we          = 1'b1;
                val_waddr       = VA_W'(32'(pick_reg) * OUT_SLOTS);
                val_wdata       = val_reg;
                selected_next   = pick_reg;
                state_next      = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            frame_reg      <= '0;
            selected_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            frame_reg      <= frame_next;
            selected_reg   <= selected_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        scan_cnt_reg <= scan_cnt_next;
        pend_idx_reg <= pend_idx_next;
        pick_reg     <= pick_next;
        oldest_reg   <= oldest_next;
        entry_reg    <= entry_next;
        run_len_reg  <= run_len_next;
        run_slot_reg <= run_slot_next;
        hit_one_reg  <= hit_one_next;
        key_reg      <= key_next;
        count_reg    <= count_next;
        val_reg      <= val_next;
        out_hit_reg  <= out_hit_next;
        out_val_reg  <= out_val_next;
        out_slot_reg <= out_slot_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

FILE: src/mrcl_checker.sv
// port checker for the memo result cache, bound to the top level
`default_nettype none

module mrcl_checker
    import mrcl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [CMD_W-1:0]     s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser,
    input logic                 m_axis_tlast
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // a miss is a single zero item
    a_miss_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("miss item not a single zero item");

    // a lookup keeps the input side busy
    a_lookup_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOOKUP) |=> !s_axis_tready)
        else $error("input ready right after a lookup");

    // no new command in the middle of a run
    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready during a result run");

    // slots of a run do not repeat from one item to the next
    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata[66:64] != $past(m_axis_tdata[66:64])))
        else $error("result slot repeated in a run");

endmodule

bind memo_result_cache_lru_core mrcl_checker u_mrcl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
